// ----- rtl/core/tcw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int DEF_SCREEN_COLUMNS = 80;
    localparam int DEF_SCREEN_ROWS    = 25;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = CHAR_W + COLOR_W;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;
    localparam logic [CELL_W-1:0]  BLANK_CELL   = {RESET_COLOR, BLANK_CODE};

endpackage

`default_nettype wire

// ----- rtl/core/tcw_screen_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram #(
    parameter int DEPTH  = tcw_pkg::DEF_SCREEN_COLUMNS * tcw_pkg::DEF_SCREEN_ROWS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire                        clk,
    input  wire                        we,
    input  wire  [ADDR_W-1:0]          waddr,
    input  wire  [tcw_pkg::CELL_W-1:0] wdata,
    input  wire  [ADDR_W-1:0]          raddr,
    output logic [tcw_pkg::CELL_W-1:0] rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tcw_addr_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_addr_unit #(
    parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS,
    parameter int ADDR_W         = $clog2(SCREEN_COLUMNS * SCREEN_ROWS)
) (
    input  wire  [tcw_pkg::ROW_W-1:0] row,
    input  wire  [tcw_pkg::COL_W-1:0] column,
    output logic [ADDR_W-1:0]         addr
);
    import tcw_pkg::*;

    // row-major cell index, row times a constant line length
    logic [ADDR_W+ROW_W-1:0] row_base;

    assign row_base = (ADDR_W+ROW_W)'(row) * (ADDR_W+ROW_W)'(SCREEN_COLUMNS);
    assign addr     = row_base[ADDR_W-1:0] + ADDR_W'(column);

endmodule

`default_nettype wire

// ----- rtl/core/tcw_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl #(
    parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS,
    parameter int ADDR_W         = $clog2(SCREEN_COLUMNS * SCREEN_ROWS)
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_wr_en,
    input  wire  [tcw_pkg::COLOR_W-1:0] cfg_wr_data,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  wire  [tcw_pkg::MODE_W-1:0]  mode,
    input  wire  [tcw_pkg::CHAR_W-1:0]  char_code,
    input  wire  [tcw_pkg::COLOR_W-1:0] cell_color,
    input  wire  [tcw_pkg::COL_W-1:0]   column,
    input  wire  [tcw_pkg::ROW_W-1:0]   row,
    output logic                        out_valid,
    input  wire                         out_stall,
    output logic [tcw_pkg::CELL_W-1:0]  cell_entry,
    output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
    output logic [tcw_pkg::COL_W-1:0]   cursor_column,
    output logic                        scrolled,
    output logic                        position_error,
    output logic [tcw_pkg::ROW_W-1:0]   au_row,
    output logic [tcw_pkg::COL_W-1:0]   au_column,
    input  wire  [ADDR_W-1:0]           au_addr,
    output logic                        mem_we,
    output logic [ADDR_W-1:0]           mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0]  mem_wdata,
    output logic [ADDR_W-1:0]           mem_raddr,
    input  wire  [tcw_pkg::CELL_W-1:0]  mem_rd_data
);
    import tcw_pkg::*;

    localparam int TOTAL_CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TOTAL_CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_LEN  = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
    localparam logic [ADDR_W-1:0] LINE_LEN  = ADDR_W'(SCREEN_COLUMNS);
    localparam logic [COL_W-1:0]  COL_LIMIT = COL_W'(SCREEN_COLUMNS);
    localparam logic [ROW_W-1:0]  ROW_LIMIT = ROW_W'(SCREEN_ROWS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_COPY  = 3'd4;
    localparam logic [2:0] S_FILL  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  cnt_reg, cnt_next;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [COLOR_W-1:0] text_color_reg;
    logic               out_valid_reg, out_valid_next;

    logic [MODE_W-1:0]  mode_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [COLOR_W-1:0] color_in_reg;
    logic [COL_W-1:0]   col_in_reg;
    logic [ROW_W-1:0]   row_in_reg;
    logic [CELL_W-1:0]  entry_reg, entry_next;
    logic               scrolled_reg, scrolled_next;
    logic               perr_reg, perr_next;

    logic [CELL_W-1:0]  out_entry_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic               out_scrolled_reg;
    logic               out_perr_reg;

    logic               in_take;
    logic               out_load;
    logic               in_range;
    logic               next_row;
    logic [COL_W-1:0]   col_inc;
    logic [ROW_W-1:0]   row_inc;

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign in_range = (col_in_reg < COL_LIMIT) && (row_in_reg < ROW_LIMIT);
    assign col_inc  = cur_col_reg + COL_W'(1);
    assign row_inc  = cur_row_reg + ROW_W'(1);

    // the put addresses the cursor, reads and writes address the given cell
    assign au_row    = (mode_reg == MODE_PUT) ? cur_row_reg : row_in_reg;
    assign au_column = (mode_reg == MODE_PUT) ? cur_col_reg : col_in_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        entry_next     = entry_reg;
        scrolled_next  = scrolled_reg;
        perr_next      = perr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        next_row       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = au_addr;
        mem_wdata      = {text_color_reg, char_reg};
        mem_raddr      = au_addr;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = BLANK_CELL;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                entry_next    = '0;
                scrolled_next = 1'b0;
                perr_next     = 1'b0;
                state_next    = S_OUT;
                case (mode_reg)
                    MODE_PUT:
                    begin
                        if (char_reg == NEWLINE_CODE)
                        begin
                            next_row = 1'b1;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            if (col_inc >= COL_LIMIT)
                            begin
                                next_row = 1'b1;
                            end
                            else
                            begin
                                cur_col_next = col_inc;
                            end
                        end
                        if (next_row)
                        begin
                            cur_col_next = '0;
                            if (row_inc >= ROW_LIMIT)
                            begin
                                // cursor already on the last row, stays there
                                scrolled_next = 1'b1;
                                cnt_next      = '0;
                                state_next    = S_COPY;
                            end
                            else
                            begin
                                cur_row_next = row_inc;
                            end
                        end
                    end
                    MODE_READ:
                    begin
                        if (in_range)
                        begin
                            state_next = S_READ;
                        end
                        else
                        begin
                            perr_next = 1'b1;
                        end
                    end
                    MODE_WRITE:
                    begin
                        mem_wdata = {color_in_reg, char_reg};
                        if (in_range)
                        begin
                            mem_we = 1'b1;
                        end
                        else
                        begin
                            perr_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_READ:
            begin
                entry_next = mem_rd_data;
                state_next = S_OUT;
            end
            S_COPY:
            begin
                // read one line ahead, write the previous read one cell behind
                mem_raddr = cnt_reg + LINE_LEN;
                mem_we    = (cnt_reg != '0);
                mem_waddr = cnt_reg - ADDR_W'(1);
                mem_wdata = mem_rd_data;
                if (cnt_reg == COPY_LEN)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = {text_color_reg, BLANK_CODE};
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cnt_reg        <= '0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            text_color_reg <= RESET_COLOR;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                text_color_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg     <= entry_next;
        scrolled_reg  <= scrolled_next;
        perr_reg      <= perr_next;
        if (in_take)
        begin
            mode_reg     <= mode;
            char_reg     <= char_code;
            color_in_reg <= cell_color;
            col_in_reg   <= column;
            row_in_reg   <= row;
        end
        if (out_load)
        begin
            out_entry_reg    <= entry_reg;
            out_row_reg      <= cur_row_reg;
            out_col_reg      <= cur_col_reg;
            out_scrolled_reg <= scrolled_reg;
            out_perr_reg     <= perr_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cell_entry     = out_entry_reg;
    assign cursor_row     = out_row_reg;
    assign cursor_column  = out_col_reg;
    assign scrolled       = out_scrolled_reg;
    assign position_error = out_perr_reg;

endmodule

`default_nettype wire

// ----- rtl/core/text_console_writer_unit.sv -----
// Character-cell text console. The screen is a single-port-write, registered-read store of
// SCREEN_ROWS x SCREEN_COLUMNS 16-bit cells (color high byte, character low byte), walked by one
// address unit and a small sequencer. After reset the block runs a clearing pass that fills
// every cell with a grey-on-black blank; in_stall stays high meanwhile, while text_color writes
// are taken at any time. Each input transfer runs from acceptance through the execute and output
// states back to idle; a cell read also passes a read state, as the store's read data is
// registered. A put or newline that leaves the last row scrolls the screen through the same store
// port, one cell per cycle: a copy of every row but the top one up by one line, then a blank fill
// of the bottom row. The result sits in an output register, so the next item is accepted while a
// result still waits for its transfer.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_unit #(
    parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_wr_en,
    input  wire  [tcw_pkg::COLOR_W-1:0] cfg_wr_data,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  wire  [tcw_pkg::MODE_W-1:0]  mode,
    input  wire  [tcw_pkg::CHAR_W-1:0]  char_code,
    input  wire  [tcw_pkg::COLOR_W-1:0] cell_color,
    input  wire  [tcw_pkg::COL_W-1:0]   column,
    input  wire  [tcw_pkg::ROW_W-1:0]   row,
    output logic                        out_valid,
    input  wire                         out_stall,
    output logic [tcw_pkg::CELL_W-1:0]  cell_entry,
    output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
    output logic [tcw_pkg::COL_W-1:0]   cursor_column,
    output logic                        scrolled,
    output logic                        position_error
);
    import tcw_pkg::*;

    localparam int DEPTH  = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [ROW_W-1:0]  au_row;
    logic [COL_W-1:0]  au_column;
    logic [ADDR_W-1:0] au_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rd_data;

    tcw_addr_unit #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .ADDR_W         (ADDR_W)
    ) u_addr_unit (
        .row    (au_row),
        .column (au_column),
        .addr   (au_addr)
    );

    tcw_screen_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_screen_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr   (mem_raddr),
        .rd_data (mem_rd_data)
    );

    tcw_ctrl #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .ADDR_W         (ADDR_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .char_code      (char_code),
        .cell_color     (cell_color),
        .column         (column),
        .row            (row),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_entry     (cell_entry),
        .cursor_row     (cursor_row),
        .cursor_column  (cursor_column),
        .scrolled       (scrolled),
        .position_error (position_error),
        .au_row         (au_row),
        .au_column      (au_column),
        .au_addr        (au_addr),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rd_data    (mem_rd_data)
    );

endmodule

`default_nettype wire

// ----- tb/text_console_writer_unit_test.sv -----
`timescale 1ns / 1ps

module text_console_writer_unit_test;
    import tcw_pkg::*;

    localparam int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS;
    localparam int SCREEN_ROWS    = DEF_SCREEN_ROWS;
    localparam int SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int RANDOM_OPS     = 340;
    localparam int SETTLE_CYCLES  = 20;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // edge positions for directed requests
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [COL_W-1:0] COL_OVER = COL_W'(SCREEN_COLUMNS);
    localparam logic [COL_W-1:0] COL_MAX  = '1;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [ROW_W-1:0] ROW_OVER = ROW_W'(SCREEN_ROWS);
    localparam logic [ROW_W-1:0] ROW_MAX  = '1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] cell_color;
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
    } console_op_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_entry;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
        logic              scrolled;
        logic              position_error;
    } console_status_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [COLOR_W-1:0] cfg_wr_data = RESET_COLOR;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [MODE_W-1:0]  mode = MODE_PUT;
    logic [CHAR_W-1:0]  char_code = '0;
    logic [COLOR_W-1:0] cell_color = '0;
    logic [COL_W-1:0]   column = '0;
    logic [ROW_W-1:0]   row = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [CELL_W-1:0]  cell_entry;
    logic [ROW_W-1:0]   cursor_row;
    logic [COL_W-1:0]   cursor_column;
    logic               scrolled;
    logic               position_error;

    // console image kept alongside the block
    logic [CELL_W-1:0]  screen_img [0:SCREEN_CELLS-1];
    int                 cur_row;
    int                 cur_col;
    logic [COLOR_W-1:0] text_color_model;

    console_op_t        op_q [$];
    console_status_t    status_q [$];
    console_status_t    got_status;
    console_status_t    want_status;
    console_op_t        pending_op;
    bit                 in_fire = 1'b0;
    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;
    int                 fail_count = 0;
    int                 ops_accepted = 0;
    int                 results_checked = 0;
    int                 scroll_count = 0;
    int                 perr_count = 0;

    text_console_writer_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .char_code      (char_code),
        .cell_color     (cell_color),
        .column         (column),
        .row            (row),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_entry     (cell_entry),
        .cursor_row     (cursor_row),
        .cursor_column  (cursor_column),
        .scrolled       (scrolled),
        .position_error (position_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // cursor to column 0 of the next row, scrolling off the bottom
    function automatic bit advance_row();
        cur_col = 0;
        cur_row++;
        if (cur_row >= SCREEN_ROWS)
        begin
            for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLUMNS; i++)
                screen_img[i] = screen_img[i + SCREEN_COLUMNS];
            for (int i = 0; i < SCREEN_COLUMNS; i++)
                screen_img[(SCREEN_ROWS - 1) * SCREEN_COLUMNS + i] = {text_color_model, BLANK_CODE};
            cur_row = SCREEN_ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic console_status_t apply_console_op(input console_op_t op);
        console_status_t res;
        bit              in_range;
        int              addr;
        res = '0;
        in_range = (int'(op.column) < SCREEN_COLUMNS) && (int'(op.row) < SCREEN_ROWS);
        addr = int'(op.row) * SCREEN_COLUMNS + int'(op.column);
        case (op.mode)
            MODE_PUT:
            begin
                if (op.char_code == NEWLINE_CODE)
                    res.scrolled = advance_row();
                else
                begin
                    screen_img[cur_row * SCREEN_COLUMNS + cur_col] = {text_color_model, op.char_code};
                    cur_col++;
                    if (cur_col >= SCREEN_COLUMNS)
                        res.scrolled = advance_row();
                end
            end
            MODE_READ:
            begin
                if (in_range)
                    res.cell_entry = screen_img[addr];
                else
                    res.position_error = 1'b1;
            end
            MODE_WRITE:
            begin
                if (in_range)
                    screen_img[addr] = {op.cell_color, op.char_code};
                else
                    res.position_error = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.cursor_row    = cur_row[ROW_W-1:0];
        res.cursor_column = cur_col[COL_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string field_name, input logic [CELL_W-1:0] want,
                               input logic [CELL_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
            fail_count++;
        end
    endtask

    function automatic void queue_op(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] ch,
                                     input logic [COLOR_W-1:0] color,
                                     input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
        console_op_t op;
        op.mode       = m;
        op.char_code  = ch;
        op.cell_color = color;
        op.column     = c;
        op.row        = r;
        op_q.push_back(op);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_byte();
        return CHAR_W'($urandom_range(255));
    endfunction

    function automatic logic [COL_W-1:0] rand_col();
        return COL_W'($urandom_range(127));
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        return ROW_W'($urandom_range(31));
    endfunction

    task automatic queue_random_ops(input int count);
        int                 n;
        int                 pick;
        logic [COL_W-1:0]   c;
        logic [ROW_W-1:0]   r;
        logic [MODE_W-1:0]  m;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(99);
            c = COL_W'($urandom_range(SCREEN_COLUMNS - 1));
            r = ROW_W'($urandom_range(SCREEN_ROWS - 1));
            if (pick < 8)
                queue_op(MODE_PUT, NEWLINE_CODE, rand_byte(), rand_col(), rand_row());
            else if (pick < 55)
                queue_op(MODE_PUT, rand_byte(), rand_byte(), rand_col(), rand_row());
            else if (pick < 68)
                queue_op(MODE_READ, rand_byte(), rand_byte(), c, r);
            else if (pick < 78)
            begin
                // write then read back the same cell
                queue_op(MODE_WRITE, rand_byte(), rand_byte(), c, r);
                queue_op(MODE_READ, rand_byte(), rand_byte(), c, r);
                n++;
            end
            else if (pick < 84)
                queue_op(MODE_WRITE, rand_byte(), rand_byte(), c, r);
            else if (pick < 90)
            begin
                m = $urandom_range(1) ? MODE_WRITE : MODE_READ;
                case ($urandom_range(2))
                    0: c = COL_W'($urandom_range(127, SCREEN_COLUMNS));
                    1: r = ROW_W'($urandom_range(31, SCREEN_ROWS));
                    default:
                    begin
                        c = COL_W'($urandom_range(127, SCREEN_COLUMNS));
                        r = ROW_W'($urandom_range(31, SCREEN_ROWS));
                    end
                endcase
                queue_op(m, rand_byte(), rand_byte(), c, r);
            end
            else if (pick < 94)
                queue_op(MODE_UNUSED, rand_byte(), rand_byte(), rand_col(), rand_row());
            else
                // bottom row sees puts and scroll blanks
                queue_op(MODE_READ, rand_byte(), rand_byte(), c, ROW_LAST);
            n++;
        end
    endtask

    task automatic wait_for_drain();
        while (op_q.size() != 0 || in_valid || status_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_text_color(input logic [COLOR_W-1:0] color);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= color;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (op_q.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    pending_op = op_q.pop_front();
                    in_valid   <= 1'b1;
                    mode       <= pending_op.mode;
                    char_code  <= pending_op.char_code;
                    cell_color <= pending_op.cell_color;
                    column     <= pending_op.column;
                    row        <= pending_op.row;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // monitor: config writes, input transfers, result checks
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire = in_valid && !in_stall;
            if (cfg_wr_en)
                text_color_model = cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                got_status = {cell_entry, cursor_row, cursor_column, scrolled, position_error};
                results_checked++;
                scroll_count += int'(got_status.scrolled);
                perr_count   += int'(got_status.position_error);
                if (status_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time, got_status);
                    fail_count++;
                end
                else
                begin
                    want_status = status_q.pop_front();
                    check_field("cell_entry", want_status.cell_entry, got_status.cell_entry);
                    check_field("cursor_row", CELL_W'(want_status.cursor_row),
                                CELL_W'(got_status.cursor_row));
                    check_field("cursor_column", CELL_W'(want_status.cursor_column),
                                CELL_W'(got_status.cursor_column));
                    check_field("scrolled", CELL_W'(want_status.scrolled),
                                CELL_W'(got_status.scrolled));
                    check_field("position_error", CELL_W'(want_status.position_error),
                                CELL_W'(got_status.position_error));
                end
            end
            if (in_fire)
            begin
                status_q.push_back(apply_console_op({mode, char_code, cell_color, column, row}));
                ops_accepted++;
            end
        end
        else
            in_fire = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int                 sender_pcts [4];
        int                 receiver_pcts [4];
        logic [COLOR_W-1:0] phase_colors [4];
        for (int i = 0; i < SCREEN_CELLS; i++)
            screen_img[i] = BLANK_CELL;
        cur_row = 0;
        cur_col = 0;
        text_color_model = RESET_COLOR;
        sender_pcts   = '{0, 54, 0, 38};
        receiver_pcts = '{0, 0, 54, 38};
        phase_colors  = '{8'h00, 8'hFF, 8'h00, 8'h00};
        phase_colors[2] = COLOR_W'($urandom_range(255));
        phase_colors[3] = COLOR_W'($urandom_range(255));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset color
        @(posedge clk);
        queue_op(MODE_READ, 8'h00, 8'h00, '0, '0);
        queue_op(MODE_PUT, 8'h41, 8'h00, '0, '0);
        queue_op(MODE_PUT, 8'h00, 8'hFF, COL_MAX, ROW_MAX);
        queue_op(MODE_PUT, 8'hFF, 8'h00, '0, '0);
        queue_op(MODE_READ, 8'h00, 8'h00, '0, '0);
        queue_op(MODE_READ, 8'h00, 8'h00, COL_W'(2), '0);
        queue_op(MODE_PUT, NEWLINE_CODE, 8'h00, '0, '0);
        queue_op(MODE_WRITE, 8'hFF, 8'hFF, COL_LAST, ROW_LAST);
        queue_op(MODE_READ, 8'h00, 8'h00, COL_LAST, ROW_LAST);
        // newline code is an ordinary byte for positioned writes and reads
        queue_op(MODE_WRITE, NEWLINE_CODE, 8'h00, '0, '0);
        queue_op(MODE_READ, NEWLINE_CODE, 8'h00, '0, '0);
        queue_op(MODE_READ, 8'h00, 8'h00, COL_OVER, '0);
        queue_op(MODE_READ, 8'h00, 8'h00, '0, ROW_OVER);
        queue_op(MODE_READ, 8'hFF, 8'hFF, COL_MAX, ROW_MAX);
        queue_op(MODE_WRITE, 8'hFF, 8'hFF, COL_MAX, ROW_MAX);
        queue_op(MODE_WRITE, 8'h55, 8'hAA, COL_OVER, ROW_LAST);
        queue_op(MODE_WRITE, 8'hAA, 8'h55, COL_LAST, ROW_OVER);
        queue_op(MODE_READ, 8'h00, 8'h00, COL_LAST, ROW_LAST);
        queue_op(MODE_UNUSED, rand_byte(), rand_byte(), rand_col(), rand_row());
        queue_op(MODE_UNUSED, 8'hFF, 8'hFF, COL_MAX, ROW_MAX);
        queue_op(MODE_PUT, BLANK_CODE, 8'h00, '0, '0);
        queue_op(MODE_READ, 8'h00, 8'h00, '0, ROW_W'(1));
        wait_for_drain();

        for (int p = 0; p < 4; p++)
        begin
            set_text_color(phase_colors[p]);
            @(posedge clk);
            sender_idle_pct    = sender_pcts[p];
            receiver_stall_pct = receiver_pcts[p];
            queue_random_ops(RANDOM_OPS);
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("%0d input transfers, %0d results checked, %0d scrolls, %0d position errors",
                 ops_accepted, results_checked, scroll_count, perr_count);
        $display("text colors %0h %0h %0h %0h over four idling and stall phases",
                 phase_colors[0], phase_colors[1], phase_colors[2], phase_colors[3]);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
